// ===== sv/ljpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ljpf_pkg
// shared widths, constants and types of the lennard-jones pair force block
// ----------------------------------------------------------------------------
package ljpf_pkg;

    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int MOM_W   = 48;
    localparam int CFG_W   = 32;
    localparam int MUL_W   = 64;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int HALF_W  = MUL_W / 2;
    localparam int QUO_W   = 53;
    localparam int POW_W   = 57;
    localparam int R2W_W   = 58;

    localparam logic [CFG_W-1:0] CUTOFF_RST = 32'd9437184;
    localparam logic [CFG_W-1:0] TSTEP_RST  = 32'd4294967;

    localparam logic [POW_W-1:0] POW_CAP = 57'h100_0000_0000_0000;
    localparam logic signed [MOM_W-1:0] POS48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [MOM_W-1:0] NEG48 = 48'sh8000_0000_0000;

    localparam logic CFG_CUTOFF = 1'b0;
    localparam logic CFG_TSTEP  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK  = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_CUT  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_POW  = 8'b0010_0000,
        S_FAC  = 8'b0100_0000,
        S_TERM = 8'b1000_0000
    } state_t;

endpackage

// ===== sv/ljpf_mul.sv =====
// ----------------------------------------------------------------------------
// ljpf_mul
// shared 64x64 unsigned multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module ljpf_mul import ljpf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [MUL_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [HALF_W-1:0] a_half, b_half;
    logic [MUL_W-1:0]  pp;
    logic [1:0]        sh;

    always_comb
    begin
        a_half    = cnt_reg[1] ? a_reg[MUL_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half    = cnt_reg[0] ? b_reg[MUL_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp        = a_half * b_half;
        sh        = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + ({{MUL_W{1'b0}}, pp} << (sh * HALF_W));
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== sv/ljpf_div.sv =====
// ----------------------------------------------------------------------------
// ljpf_div
// restoring divider, 2^52 / divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ljpf_div import ljpf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [CFG_W-1:0] div_reg, div_next, rem_reg, rem_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [CFG_W:0]   trial;
    logic             qbit;

    always_comb
    begin
        // the dividend has a single one bit, fed on the first step
        trial     = {rem_reg, (cnt_reg == 6'd0)};
        qbit      = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            div_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? CFG_W'(trial - {1'b0, div_reg}) : trial[CFG_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], qbit};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/lj_pair_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// lj_pair_force_accumulator
// lennard-jones pair force, accumulated over a neighbor list, fixed point
// ----------------------------------------------------------------------------
// One item at a time. A partnerless item or a pair beyond 64 units ends
// in the check; a pair that fails the cutoff test ends after the three
// squares; a pair within the cutoff runs three squares, four powers, the
// factor and three terms on the shared multiplier (11 products) and the
// bit-serial divider that forms 1/r2. An item that emits ends in S_CHK,
// where the emit takes place. in_ready is high only while the sequencer
// is idle. A result sits in an output register until taken; an item that
// emits waits for it.
module lj_pair_force_accumulator import ljpf_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] key_x,
    input  logic signed [POS_W-1:0] key_y,
    input  logic signed [POS_W-1:0] key_z,
    input  logic signed [POS_W-1:0] nbr_x,
    input  logic signed [POS_W-1:0] nbr_y,
    input  logic signed [POS_W-1:0] nbr_z,
    input  logic signed [MOM_W-1:0] mom_x,
    input  logic signed [MOM_W-1:0] mom_y,
    input  logic signed [MOM_W-1:0] mom_z,
    input  logic                    neighbor_valid,
    input  logic                    last_pair,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [MOM_W-1:0] new_mom_x,
    output logic signed [MOM_W-1:0] new_mom_y,
    output logic signed [MOM_W-1:0] new_mom_z
);

    state_t state_reg, state_next;
    logic [CFG_W-1:0] cutoff_reg, tstep_reg;
    logic [1:0] step_reg, step_next;
    logic wait_reg, wait_next;
    logic emit_pend_reg, emit_pend_next;
    logic out_valid_reg, out_valid_next;
    logic signed [MOM_W-1:0] sum_reg [3];
    logic signed [MOM_W-1:0] sum_next [3];
    logic signed [MOM_W-1:0] mom_reg [3];
    logic signed [MOM_W-1:0] out_reg [3];
    logic signed [MOM_W-1:0] out_next [3];
    logic signed [DIFF_W-1:0] d_reg [3];
    logic [DIFF_W-1:0] dmag [3];
    logic valid_reg, last_reg;
    logic [R2W_W-1:0] r2w_reg, r2w_next;
    logic [QUO_W-1:0] s_reg;
    logic [POW_W-1:0] s2_reg, s3_reg, s4_reg, s7_reg, pow_val;
    logic [MOM_W-1:0] fmag_reg, fmag_val, fcap;
    logic fneg_reg, fneg_next;
    logic signed [MUL_W-1:0] dd, p24, p48;
    logic [MUL_W-1:0] ddmag;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0] quo;
    logic [CFG_W+1:0] r2;
    logic mul_start, mul_done, div_start, div_done;
    logic far, finish, emit_ok;
    logic [DIFF_W-1:0] dsel_mag;
    logic dsel_neg;
    logic [QUO_W-1:0] tmag;
    logic signed [QUO_W:0] term;
    logic signed [MOM_W+6:0] acc_sum;
    logic signed [MOM_W:0] osum [3];

    ljpf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    ljpf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  ((r2[CFG_W-1:0] == '0) ? CFG_W'(1) : r2[CFG_W-1:0]),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = d_reg[i][DIFF_W-1] ? DIFF_W'(-d_reg[i]) : DIFF_W'(d_reg[i]);
        end
        far      = (dmag[0][DIFF_W-1:28] != '0) || (dmag[1][DIFF_W-1:28] != '0)
                || (dmag[2][DIFF_W-1:28] != '0);
        r2       = r2w_reg[R2W_W-1:24];
        dsel_mag = dmag[step_reg];
        dsel_neg = d_reg[step_reg][DIFF_W-1];
        p24      = MUL_W'({s4_reg, 4'b0}) + MUL_W'({s4_reg, 3'b0});
        p48      = MUL_W'({s7_reg, 5'b0}) + MUL_W'({s7_reg, 4'b0});
        dd       = p24 - p48;
        ddmag    = dd[MUL_W-1] ? MUL_W'(-dd) : MUL_W'(dd);
        pow_val  = (prod[PROD_W-1:32] > {39'b0, POW_CAP}) ? POW_CAP : prod[88:32];
        fcap     = fneg_reg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        fmag_val = (prod[PROD_W-1:32] > {48'b0, fcap}) ? fcap : prod[79:32];
        tmag     = prod[74:22];
        term     = (fneg_reg ^ dsel_neg) ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
        acc_sum  = (MOM_W+7)'(sum_reg[step_reg]) + (MOM_W+7)'(term);

        case (state_reg)
            S_SQ:    begin mul_a = MUL_W'(dsel_mag); mul_b = MUL_W'(dsel_mag); end
            S_POW:
            begin
                case (step_reg)
                    2'd0:    begin mul_a = MUL_W'(s_reg);  mul_b = MUL_W'(s_reg);  end
                    2'd1:    begin mul_a = MUL_W'(s2_reg); mul_b = MUL_W'(s_reg);  end
                    2'd2:    begin mul_a = MUL_W'(s2_reg); mul_b = MUL_W'(s2_reg); end
                    default: begin mul_a = MUL_W'(s4_reg); mul_b = MUL_W'(s3_reg); end
                endcase
            end
            S_FAC:   begin mul_a = ddmag; mul_b = MUL_W'(tstep_reg); end
            S_TERM:  begin mul_a = MUL_W'(fmag_reg); mul_b = MUL_W'(dsel_mag); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase

        for (int i = 0; i < 3; i++)
        begin
            osum[i] = (MOM_W+1)'(mom_reg[i]) + (MOM_W+1)'(sum_reg[i]);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        wait_next      = wait_reg;
        emit_pend_next = emit_pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        r2w_next       = r2w_reg;
        fneg_next      = fneg_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        finish         = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = sum_reg[i];
            out_next[i] = out_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHK;
                    r2w_next   = '0;
                end
            end
            S_CHK:
            begin
                step_next = 2'd0;
                wait_next = 1'b0;
                if (!valid_reg || far)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ, S_POW, S_TERM:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    step_next = step_reg + 2'd1;
                    if (state_reg == S_SQ)
                    begin
                        r2w_next = r2w_reg + prod[R2W_W-1:0];
                        if (step_reg == 2'd2)
                        begin
                            state_next = S_CUT;
                        end
                    end
                    else if (state_reg == S_POW)
                    begin
                        if (step_reg == 2'd3)
                        begin
                            state_next = S_FAC;
                        end
                    end
                    else
                    begin
                        if (acc_sum > (MOM_W+7)'(POS48))
                        begin
                            sum_next[step_reg] = POS48;
                        end
                        else if (acc_sum < (MOM_W+7)'(NEG48))
                        begin
                            sum_next[step_reg] = NEG48;
                        end
                        else
                        begin
                            sum_next[step_reg] = acc_sum[MOM_W-1:0];
                        end
                        if (step_reg == 2'd2)
                        begin
                            finish = 1'b1;
                        end
                    end
                    if ((state_reg == S_SQ && step_reg == 2'd2) || state_reg == S_POW
                        && step_reg == 2'd3)
                    begin
                        step_next = 2'd0;
                    end
                end
            end
            S_CUT:
            begin
                if (r2 > {2'b0, cutoff_reg})
                begin
                    finish = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                wait_next = 1'b0;
                if (div_done)
                begin
                    state_next = S_POW;
                    step_next  = 2'd0;
                end
            end
            S_FAC:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    fneg_next = dd[MUL_W-1];
                end
                else if (mul_done)
                begin
                    wait_next  = 1'b0;
                    step_next  = 2'd0;
                    state_next = S_TERM;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
            if (last_reg || !valid_reg)
            begin
                state_next     = S_CHK;
                emit_pend_next = 1'b1;
            end
        end

        // emit once the output register is free
        emit_ok = emit_pend_reg && (!out_valid_reg || out_ready);
        if (emit_pend_reg)
        begin
            state_next = S_CHK;
            if (emit_ok)
            begin
                state_next     = S_IDLE;
                emit_pend_next = 1'b0;
                out_valid_next = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    if (osum[i] > (MOM_W+1)'(POS48))
                    begin
                        out_next[i] = POS48;
                    end
                    else if (osum[i] < (MOM_W+1)'(NEG48))
                    begin
                        out_next[i] = NEG48;
                    end
                    else
                    begin
                        out_next[i] = osum[i][MOM_W-1:0];
                    end
                    sum_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            wait_reg      <= 1'b0;
            emit_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cutoff_reg    <= CUTOFF_RST;
            tstep_reg     <= TSTEP_RST;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wait_reg      <= wait_next;
            emit_pend_reg <= emit_pend_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CUTOFF: cutoff_reg <= cfg_data;
                    CFG_TSTEP:  tstep_reg  <= cfg_data;
                    default:    cutoff_reg <= cutoff_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r2w_reg  <= r2w_next;
        fneg_reg <= fneg_next;
        for (int i = 0; i < 3; i++)
        begin
            out_reg[i] <= out_next[i];
        end
        if (state_reg == S_IDLE && in_valid)
        begin
            d_reg[0]   <= DIFF_W'(nbr_x) - DIFF_W'(key_x);
            d_reg[1]   <= DIFF_W'(nbr_y) - DIFF_W'(key_y);
            d_reg[2]   <= DIFF_W'(nbr_z) - DIFF_W'(key_z);
            mom_reg[0] <= mom_x;
            mom_reg[1] <= mom_y;
            mom_reg[2] <= mom_z;
            valid_reg  <= neighbor_valid;
            last_reg   <= last_pair;
        end
        if (div_done)
        begin
            s_reg <= quo;
        end
        if (state_reg == S_POW && wait_reg && mul_done)
        begin
            case (step_reg)
                2'd0:    s2_reg <= pow_val;
                2'd1:    s3_reg <= pow_val;
                2'd2:    s4_reg <= pow_val;
                default: s7_reg <= pow_val;
            endcase
        end
        if (state_reg == S_FAC && wait_reg && mul_done)
        begin
            fmag_reg <= fmag_val;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign new_mom_x = out_reg[0];
    assign new_mom_y = out_reg[1];
    assign new_mom_z = out_reg[2];

endmodule
